// ----- hw/rtl/fic_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware image CRC validator package
// Shared constants and the transfer payload types of the image check block.
// ----------------------------------------------------------------------------
package fic_pkg;

    // Default number of leading bytes looked at by the blank-flash check.
    localparam int BLANK_CHECK_BYTES_DEF = 128;

    // Reflected CRC-16 polynomial (KERMIT style), start value zero.
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'h0000;

    // Value of an erased flash byte.
    localparam logic [7:0]  ERASED_BYTE = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } image_byte_t;

    typedef struct packed {
        logic        image_valid;
        logic        image_blank;
        logic [15:0] computed_crc;
        logic [15:0] stored_crc;
    } image_result_t;

endpackage : fic_pkg
`default_nettype wire

// ----- hw/rtl/firmware_image_crc_validator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware image CRC validator
// Checks a firmware image streamed in one byte per transfer: CRC-16/KERMIT
// over all but the final two bytes, compared against those two bytes taken
// as a little-endian stored CRC, plus a blank (all 0xFF) check on the first
// BLANK_CHECK_BYTES bytes.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload                 Transfers
//  -------   --------------------------   ---------------------   ---------------------
//  byte      byte_valid / byte_ready      byte_item (data,last)   one per image byte
//  result    result_valid / result_ready  result_item             one per image
//
// Each byte is folded into the running state at the edge where its transfer
// completes, and a final byte loads the result register at that edge, so
// the result is offered from the next cycle on.
// The combinational byte CRC update sets the clock path. Only a result held
// back by result_ready low stalls the byte channel; one taken in the same
// cycle does not. Reset clears the CRC, delay line, count and result valid flag.
// ----------------------------------------------------------------------------
module firmware_image_crc_validator
#(
    parameter int BLANK_CHECK_BYTES = fic_pkg::BLANK_CHECK_BYTES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  byte_valid,
    output logic                       byte_ready,
    input  wire fic_pkg::image_byte_t  byte_item,

    output logic                       result_valid,
    input  wire logic                  result_ready,
    output fic_pkg::image_result_t     result_item
);

    // The byte count only needs to reach the blank-check length.
    localparam int CNT_W = $clog2(BLANK_CHECK_BYTES + 1);
    localparam logic [CNT_W-1:0] CHECK_LEN = CNT_W'(BLANK_CHECK_BYTES);
    localparam logic [CNT_W-1:0] TWO_BYTES = CNT_W'(2);

    // Running image state.
    logic [15:0]      crc_reg,       crc_next;
    logic [7:0]       held_old_reg,  held_old_next;
    logic [7:0]       held_new_reg,  held_new_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic             all_ones_reg,  all_ones_next;

    // Result register.
    logic                   res_valid_reg, res_valid_next;
    fic_pkg::image_result_t res_item_reg,  res_item_next;

    logic                   byte_xfer;
    logic [15:0]            crc_stepped;
    logic [15:0]            crc_upd;
    logic                   all_ones_upd;
    logic [15:0]            stored_crc;

    // A byte may enter whenever the result register is empty or is being
    // emptied in this cycle.
    assign byte_ready = !res_valid_reg || result_ready;
    assign byte_xfer  = byte_valid && byte_ready;

    // The oldest held byte enters the CRC.
    fic_crc16_byte u_crc_byte
    (
        .crc     (crc_reg),
        .data    (held_old_reg),
        .crc_out (crc_stepped)
    );

    always_comb
    begin
        // Once two bytes have been seen, the delay line holds real image data.
        crc_upd      = (count_reg >= TWO_BYTES) ? crc_stepped : crc_reg;
        // The blank check only looks at the leading bytes.
        all_ones_upd = all_ones_reg;
        if (count_reg < CHECK_LEN)
        begin
            all_ones_upd = all_ones_reg && (byte_item.data_byte == fic_pkg::ERASED_BYTE);
        end
        // The final two bytes, first one low.
        stored_crc = {byte_item.data_byte, held_new_reg};
    end

    always_comb
    begin
        crc_next       = crc_reg;
        held_old_next  = held_old_reg;
        held_new_next  = held_new_reg;
        count_next     = count_reg;
        all_ones_next  = all_ones_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_item_next  = res_item_reg;

        if (byte_xfer)
        begin
            if (byte_item.last_byte)
            begin
                // Emit the verdict and start over for the next image.
                res_valid_next             = 1'b1;
                res_item_next.image_blank  = all_ones_upd;
                res_item_next.computed_crc = crc_upd;
                res_item_next.stored_crc   = stored_crc;
                res_item_next.image_valid  = !all_ones_upd && (crc_upd == stored_crc);

                crc_next      = fic_pkg::CRC_INIT;
                held_old_next = 8'h00;
                held_new_next = 8'h00;
                count_next    = '0;
                all_ones_next = 1'b1;
            end
            else
            begin
                crc_next      = crc_upd;
                held_old_next = held_new_reg;
                held_new_next = byte_item.data_byte;
                all_ones_next = all_ones_upd;
                if (count_reg < CHECK_LEN)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= fic_pkg::CRC_INIT;
            held_old_reg  <= 8'h00;
            held_new_reg  <= 8'h00;
            count_reg     <= '0;
            all_ones_reg  <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            held_old_reg  <= held_old_next;
            held_new_reg  <= held_new_next;
            count_reg     <= count_next;
            all_ones_reg  <= all_ones_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_item_reg;

endmodule : firmware_image_crc_validator
`default_nettype wire

// ----- hw/rtl/fic_crc16_byte.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// CRC-16 byte update
// Advances a reflected CRC-16 by one whole byte in combinational logic.
// ----------------------------------------------------------------------------
module fic_crc16_byte
(
    input  wire logic [15:0] crc,
    input  wire logic [7:0]  data,
    output logic      [15:0] crc_out
);

    logic [15:0] work;

    // Eight bit steps of the shift register, each a shift with an xor when the low bit is set.
    always_comb
    begin
        work = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (work[0])
            begin
                work = (work >> 1) ^ fic_pkg::CRC_POLY;
            end
            else
            begin
                work = work >> 1;
            end
        end
        crc_out = work;
    end

endmodule : fic_crc16_byte
`default_nettype wire

// ----- hw/rtl/fic_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware image CRC validator checker
// Port-level assertions on the validator, attached by a bind statement.
// ----------------------------------------------------------------------------
module fic_checker
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   byte_valid,
    input wire logic                   byte_ready,
    input wire fic_pkg::image_byte_t   byte_item,
    input wire logic                   result_valid,
    input wire logic                   result_ready,
    input wire fic_pkg::image_result_t result_item
);

    // A final byte transfer produces a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_ready && byte_item.last_byte) |=> result_valid)
        else $error("final byte transfer gave no result");

    // A valid image is never blank.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.image_valid) |-> !result_item.image_blank)
        else $error("image reported valid and blank");

    // A valid image has matching CRCs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.image_valid)
            |-> (result_item.computed_crc == result_item.stored_crc))
        else $error("image reported valid with differing CRCs");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_item)))
        else $error("stalled result changed");

endmodule : fic_checker

bind firmware_image_crc_validator fic_checker u_fic_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);
`default_nettype wire

// ----- bench/image_check_board_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image check scoreboard
// Tracks the running CRC, delay line and erased-flash state of the image
// being streamed, and checks each result against the oldest expected one.
// ----------------------------------------------------------------------------
package image_check_board_pkg;

    import fic_pkg::*;

    class image_check_board;

        localparam int MAX_REPORTS = 10;

        int unsigned   blank_len;

        // State of the image currently being streamed in.
        logic [15:0]   running_crc;
        logic [7:0]    delay_line [2];
        int unsigned   bytes_seen;
        bit            all_erased;

        image_result_t expected_results [$];

        int unsigned   failures;
        int unsigned   checked;
        int unsigned   images_valid;
        int unsigned   images_blank;
        int unsigned   images_total;

        function new(int unsigned blank_len);
            this.blank_len = blank_len;
            failures       = 0;
            checked        = 0;
            images_valid   = 0;
            images_blank   = 0;
            images_total   = 0;
            restart();
        endfunction

        function void restart();
            running_crc   = CRC_INIT;
            delay_line[0] = 8'h00;
            delay_line[1] = 8'h00;
            bytes_seen    = 0;
            all_erased    = 1'b1;
        endfunction

        // One byte of the reflected CRC-16, least significant bit first.
        static function logic [15:0] kermit_fold(logic [15:0] crc, logic [7:0] data);
            logic [15:0] c;
            c = crc ^ {8'h00, data};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void note_byte(image_byte_t item);
            image_result_t want;
            if (bytes_seen >= 2)
                running_crc = kermit_fold(running_crc, delay_line[0]);
            delay_line[0] = delay_line[1];
            delay_line[1] = item.data_byte;
            if (bytes_seen < blank_len)
            begin
                if (item.data_byte != ERASED_BYTE)
                    all_erased = 1'b0;
                bytes_seen++;
            end
            if (item.last_byte)
            begin
                want.stored_crc   = {delay_line[1], delay_line[0]};
                want.computed_crc = running_crc;
                want.image_blank  = all_erased;
                want.image_valid  = !all_erased && (running_crc == want.stored_crc);
                expected_results.push_back(want);
                images_total++;
                if (want.image_valid)
                    images_valid++;
                if (want.image_blank)
                    images_blank++;
                restart();
            end
        endfunction

        function void check_result(image_result_t got);
            image_result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("Unexpected result: valid=%0b blank=%0b crc=%04h stored=%04h",
                             got.image_valid, got.image_blank, got.computed_crc,
                             got.stored_crc);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.image_valid !== want.image_valid || got.image_blank !== want.image_blank
                || got.computed_crc !== want.computed_crc
                || got.stored_crc !== want.stored_crc)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("Result %0d mismatch: expected valid=%0b blank=%0b crc=%04h %s%04h, %s",
                             checked, want.image_valid, want.image_blank, want.computed_crc,
                             "stored=", want.stored_crc,
                             $sformatf("got valid=%0b blank=%0b crc=%04h stored=%04h",
                                       got.image_valid, got.image_blank, got.computed_crc,
                                       got.stored_crc));
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

    endclass

endpackage : image_check_board_pkg

// ----- bench/firmware_image_crc_validator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Firmware image CRC validator testbench
// Streams firmware images through the byte channel, half of the random ones
// well-formed with a correct little-endian CRC, alongside corrupted, erased
// and noise images, and checks every result transfer against a scoreboard
// that tracks the CRC and blank check byte by byte. Both channels idle at
// random in several phases, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module firmware_image_crc_validator_tb;

    import fic_pkg::*;
    import image_check_board_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 4;
    localparam int BYTES_PER_PHASE = 480;
    // The receiver hold-off is the longest legitimate stretch with no
    // transfer at all, so the watchdog limit sits well above it.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 3000;
    // The result register is a single stage, so the drain catches any stray
    // result once the last one has been taken.
    localparam int DRAIN_CYCLES    = 8;

    logic          clk;
    logic          rst_n;
    logic          byte_valid;
    logic          byte_ready;
    image_byte_t   byte_item;
    logic          result_valid;
    logic          result_ready;
    image_result_t result_item;

    int unsigned   send_idle_pct        = 0;
    int unsigned   recv_stall_pct       = 0;
    bit            hold_request         = 1'b0;
    int unsigned   bytes_sent           = 0;
    int unsigned   stalled_input_cycles = 0;

    image_check_board board;

    firmware_image_crc_validator
    #(
        .BLANK_CHECK_BYTES (BLANK_CHECK_BYTES_DEF)
    )
    dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Appends the CRC of the payload, low byte first, so that the block
    // should report the image as valid (unless it looks erased).
    function automatic byte_q_t with_crc(input byte_q_t payload);
        byte_q_t     img;
        logic [15:0] crc;
        img = payload;
        crc = CRC_INIT;
        foreach (payload[i])
            crc = image_check_board::kermit_fold(crc, payload[i]);
        img.push_back(crc[7:0]);
        img.push_back(crc[15:8]);
        return img;
    endfunction

    // Builds one random image. Most carry a CRC, some of those with a single
    // bit flipped; the rest are erased-looking images and plain noise.
    // Most images are short; a few run well past the blank check window.
    function automatic byte_q_t random_image();
        byte_q_t     img;
        int unsigned kind;
        int unsigned len;
        int unsigned pos;
        kind = $urandom_range(99);
        len  = ($urandom_range(49) == 0) ? $urandom_range(300, 120) : $urandom_range(24, 1);
        if (kind < 65)
        begin
            for (int i = 0; i + 1 < len; i++)
                img.push_back(8'($urandom_range(255)));
            img = with_crc(img);
            if (kind >= 50)
            begin
                pos      = $urandom_range(img.size() - 1);
                img[pos] = img[pos] ^ (8'h01 << $urandom_range(7));
            end
        end
        else if (kind < 80)
        begin
            // Erased flash: 0xFF throughout the check window, anything after.
            if ($urandom_range(3) == 0)
                len = $urandom_range(300, 120);
            for (int i = 0; i < len; i++)
                img.push_back((i < BLANK_CHECK_BYTES_DEF) ? ERASED_BYTE
                                                          : 8'($urandom_range(255)));
            // Spoil it at a random place or just either side of the window edge, or leave it.
            case ($urandom_range(3))
                0: img[$urandom_range(len - 1)] = 8'($urandom_range(255));
                1: if (len >= BLANK_CHECK_BYTES_DEF)
                       img[BLANK_CHECK_BYTES_DEF - 1] = 8'hFE;
                2: if (len > BLANK_CHECK_BYTES_DEF)
                       img[BLANK_CHECK_BYTES_DEF] = 8'h00;
                default: ;
            endcase
        end
        else
        begin
            for (int i = 0; i < len; i++)
                img.push_back(8'($urandom_range(255)));
        end
        return img;
    endfunction

    // Offers one byte and waits for its transfer. Valid is only lowered
    // when a gap is taken, so it never drops and rises within one step.
    task automatic send_byte(input image_byte_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        board.note_byte(item);
        bytes_sent++;
    endtask

    task automatic send_image(input byte_q_t img);
        image_byte_t item;
        foreach (img[i])
        begin
            item.data_byte = img[i];
            item.last_byte = (i == img.size() - 1);
            send_byte(item);
        end
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = bytes_sent + BYTES_PER_PHASE;
        while (bytes_sent < target)
            send_image(random_image());
    endtask

    // Receiver: ready is redrawn every cycle, except during a requested
    // hold-off, when it stays low throughout.
    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor. Values are read at the edge, before any update made
    // there takes effect, so they are the ones the transfer completed with.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_result(result_item);
        if (rst_n && byte_valid && !byte_ready)
            stalled_input_cycles++;
    end

    // Watchdog: ends the run once no transfer has happened on either
    // channel for too long.
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && byte_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
        $display("firmware_image_crc_validator regression: fail");
        $finish;
    end

    initial
    begin
        byte_q_t img;

        board = new(BLANK_CHECK_BYTES_DEF);
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed images: one-byte images (the older delay slot still holds
        // zero, so an all-zero byte even matches), two-byte images with no
        // payload before the CRC bytes, a short erased image, a nearly erased
        // one, and short well-formed images, one with the extreme byte values.
        img = {8'h00};
        send_image(img);
        img = {8'hFF};
        send_image(img);
        img = {8'h5A};
        send_image(img);
        img = {8'h00, 8'h00};
        send_image(img);
        img = {8'h34, 8'h12};
        send_image(img);
        img = {8'hFF, 8'hFF, 8'hFF};
        send_image(img);
        img = {8'hFF, 8'hFF, 8'h00};
        send_image(img);
        img = {8'h31, 8'h32, 8'h33};
        send_image(with_crc(img));
        img = {8'hFF, 8'h00, 8'h80, 8'h01};
        send_image(with_crc(img));

        // Random images under each mix of sender gaps and receiver stalls.
        run_phase(0, 0);
        run_phase(54, 0);
        run_phase(0, 54);
        run_phase(27, 27);

        // Back-pressure: the receiver holds off while the sender keeps
        // offering, so a result is held and the byte channel must stall.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        repeat (12)
            send_image(random_image());

        // Valid drops at the edge of the final byte transfer.
        byte_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Streamed %0d bytes in %0d images; %0d results checked, %0d valid, %0d blank.",
                 bytes_sent, board.images_total, board.checked, board.images_valid,
                 board.images_blank);
        $display("Byte channel stalled for %0d cycles; %0d failures.",
                 stalled_input_cycles, board.failures);
        if (board.failures == 0 && board.pending() == 0)
            $display("firmware_image_crc_validator regression: pass");
        else
            $display("firmware_image_crc_validator regression: fail");
        $finish;
    end

endmodule : firmware_image_crc_validator_tb

// ----- firmware_image_crc_validator.f -----
hw/rtl/fic_pkg.sv
hw/rtl/fic_crc16_byte.sv
hw/rtl/firmware_image_crc_validator.sv
hw/rtl/fic_checker.sv
bench/image_check_board_pkg.sv
bench/firmware_image_crc_validator_tb.sv
